// File: sv/ppu_pkg.sv
// Package: types and constants for the particle pool update block.
`default_nettype none
package ppu_pkg;

  localparam int LIFE_W  = 12;
  localparam int SPEED_W = 16;
  localparam int POS_W   = 24;
  localparam int SIZE_W  = 16;
  localparam int CH_W    = 8;
  localparam int DELTA_W = 10;
  localparam int SLOT_W  = 6;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_SPAWN_LIFE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_Z      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_RED   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_GREEN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_BLUE  = 3'd4;

  localparam logic ACT_SPAWN = 1'b0;
  localparam logic ACT_TICK  = 1'b1;

  typedef enum logic [1:0] {
    KIND_SPAWN = 2'd0,
    KIND_LIVE  = 2'd1,
    KIND_EMPTY = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SPAWN,
    ST_READ,
    ST_CALC,
    ST_EMIT,
    ST_EMPTY
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic take_item;   // latch input word, load slot counter, clear flags
    logic scan_step;   // advance slot counter
    logic spawn_write; // write new particle at found slot
    logic read_slot;   // read slot at counter
    logic calc;        // compute update, clear valid bit of a dying slot
    logic load_out;    // hold survivor, emit the one held before
    logic load_empty;  // emit held survivor as last, or empty marker
    logic load_spawn;  // load spawn ack
  } ppu_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic action;
    logic cur_valid;   // slot at counter valid
    logic scan_done;   // counter at last slot (spawn: search has wrapped)
    logic found;       // free slot located during search
    logic survives;    // computed particle survives
  } ppu_sts_t;

  function automatic logic [CH_W-1:0] decay(input logic [CH_W-1:0] c,
                                            input logic [CH_W-1:0] t);
    logic [CH_W+4-1:0] num;
    logic [CH_W+4+12-1:0] prod;
    logic [CH_W-1:0] q;
    logic [CH_W+4-1:0] r;
    begin
      num  = 12'(9 * c) + 12'(t);
      // divide by 10 via reciprocal 6554/65536 with one correction
      prod = 24'(num) * 24'd6554;
      q    = prod[16 +: CH_W];
      r    = num - 12'(q * 10);
      if (r >= 12'd10) q = q + 1'b1;
      else if (r[11]) q = q - 1'b1;
      decay = (c > t) ? q : t;
    end
  endfunction

endpackage
`default_nettype wire

// File: sv/ppu_if.sv
// Interface: valid/ready stream channel carrying one payload word.
`default_nettype none
interface ppu_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: sv/particle_pool_update.sv
// Top level: particle pool with spawn search and per-tick update sweep.
//  channel | dir | handshake      | word
//  in_ch   | in  | valid/ready    | action, delta, speed_x/y/z, opacity, particle_size
//  out_ch  | out | valid/ready    | kind, slot, pos_x/y/z, size_out, red, green, blue,
//          |     |                | alpha_out, last
//  cfg     | in  | cfg_we         | cfg_index, cfg_data
// A spawn searches one slot per cycle for a free slot, starting at the last spawn slot.
// A tick sweeps every slot in turn through the single read port of the slot memory;
// a live slot then passes through the calc and emit states.
// Reset is synchronous; slot contents are not cleared, only valid bits.
// A stalled output holds the sweep at the slot waiting to be emitted.
`default_nettype none
module particle_pool_update import ppu_pkg::*; #(
  parameter int POOL_DEPTH = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  ppu_if.sink                       in_ch,
  ppu_if.source                     out_ch,
  input  wire logic                 cfg_we,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_W-1:0]     cfg_data
);

  logic [LIFE_W-1:0] spawn_life;
  logic [SPEED_W-1:0] start_z;
  logic [CH_W-1:0] target_red, target_green, target_blue;

  always_ff @(posedge clk) begin
    if (rst) begin
      spawn_life <= LIFE_W'(307);
      start_z <= SPEED_W'(13);
      target_red <= CH_W'(220);
      target_green <= CH_W'(146);
      target_blue <= CH_W'(2);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SPAWN_LIFE: spawn_life <= cfg_data[LIFE_W-1:0];
        REG_START_Z: start_z <= cfg_data;
        REG_TARGET_RED: target_red <= cfg_data[CH_W-1:0];
        REG_TARGET_GREEN: target_green <= cfg_data[CH_W-1:0];
        REG_TARGET_BLUE: target_blue <= cfg_data[CH_W-1:0];
        default: ;
      endcase
    end
  end

  ppu_cmd_t cmd;
  ppu_sts_t sts;
  logic out_valid, last_bit;
  logic [2+SLOT_W+3*POS_W+SIZE_W+4*CH_W:0] out_word;

  ppu_ctrl u_ctrl (
    .clk, .rst,
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_free (!out_valid || out_ch.ready),
    .sts, .cmd
  );

  ppu_datapath #(.POOL_DEPTH(POOL_DEPTH)) u_dp (
    .clk, .rst, .cmd, .sts,
    .in_action (in_ch.data.action),
    .in_delta (in_ch.data.delta),
    .in_speed ({in_ch.data.speed_z, in_ch.data.speed_y, in_ch.data.speed_x}),
    .in_opacity (in_ch.data.opacity),
    .in_size (in_ch.data.particle_size),
    .spawn_life, .start_z,
    .targets ({target_blue, target_green, target_red}),
    .out_valid, .out_ready (out_ch.ready), .out_word,
    .last_busy_last (last_bit)
  );

  assign out_ch.valid = out_valid;
  assign {out_ch.data.kind, out_ch.data.slot, out_ch.data.pos_z, out_ch.data.pos_y,
          out_ch.data.pos_x, out_ch.data.size_out, out_ch.data.blue, out_ch.data.green,
          out_ch.data.red, out_ch.data.alpha_out, out_ch.data.last} = out_word;

`ifndef SYNTH
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_word))
    else $error("output word changed while stalled");
  a_ready_idle: assert property (@(posedge clk) disable iff (rst)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("input accepted while busy");
  a_last_mark: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.data.kind != KIND_LIVE |-> last_bit)
    else $error("single result missing last");
`endif

endmodule
`default_nettype wire

// File: sv/ppu_ctrl.sv
// Controller: sequencer for spawn search and tick sweep.
`default_nettype none
module ppu_ctrl import ppu_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     in_valid,
  output logic          in_ready,
  input  wire logic     out_free,
  input  wire ppu_sts_t sts,
  output ppu_cmd_t      cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take_item = 1'b1;
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (sts.action == ACT_TICK) begin
          cmd.read_slot = 1'b1;
          state_next = ST_READ;
        end else if (sts.found || sts.scan_done) begin
          state_next = ST_SPAWN;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      ST_SPAWN: begin
        if (out_free) begin
          cmd.spawn_write = 1'b1;
          cmd.load_spawn = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_READ: begin
        if (sts.cur_valid) state_next = ST_CALC;
        else if (sts.scan_done) state_next = ST_EMPTY;
        else begin
          cmd.scan_step = 1'b1;
          cmd.read_slot = 1'b1;
        end
      end
      ST_CALC: begin
        cmd.calc = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!sts.survives) begin
          if (sts.scan_done) state_next = ST_EMPTY;
          else begin
            cmd.scan_step = 1'b1;
            cmd.read_slot = 1'b1;
            state_next = ST_READ;
          end
        end else if (out_free) begin
          cmd.load_out = 1'b1;
          if (sts.scan_done) state_next = ST_EMPTY;
          else begin
            cmd.scan_step = 1'b1;
            cmd.read_slot = 1'b1;
            state_next = ST_READ;
          end
        end
      end
      ST_EMPTY: begin
        if (out_free) begin
          cmd.load_empty = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// File: sv/ppu_datapath.sv
// Datapath: slot memories, slot counter, update arithmetic and output register.
`default_nettype none
module ppu_datapath import ppu_pkg::*; #(
  parameter int POOL_DEPTH = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire ppu_cmd_t             cmd,
  output ppu_sts_t                  sts,
  input  wire logic                 in_action,
  input  wire logic [DELTA_W-1:0]   in_delta,
  input  wire logic [3*SPEED_W-1:0] in_speed,
  input  wire logic [CH_W-1:0]      in_opacity,
  input  wire logic [SIZE_W-1:0]    in_size,
  input  wire logic [LIFE_W-1:0]    spawn_life,
  input  wire logic [SPEED_W-1:0]   start_z,
  input  wire logic [3*CH_W-1:0]    targets,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [2+SLOT_W+3*POS_W+SIZE_W+4*CH_W:0] out_word,
  output logic                      last_busy_last
);

  localparam int IW = $clog2(POOL_DEPTH);
  localparam int MW = LIFE_W + 3*POS_W + 3*SPEED_W + 4*CH_W + SIZE_W;

  logic [POOL_DEPTH-1:0] valid_bits;
  logic [MW-1:0] mem [POOL_DEPTH];
  logic [MW-1:0] rd;
  logic [IW-1:0] idx, search_start, found_idx;
  logic found, action, any_emitted;
  logic [DELTA_W-1:0] delta;
  logic [3*SPEED_W-1:0] speed;
  logic [CH_W-1:0] opacity;
  logic [SIZE_W-1:0] psize;
  logic wrapped;

  // survivor held until the next one shows whether it is the last
  logic [2+SLOT_W+3*POS_W+SIZE_W+4*CH_W-1:0] pend;

  // calc pipeline registers
  logic survives;
  logic [LIFE_W-1:0] life_new;
  logic signed [SPEED_W+DELTA_W:0] prod [3];
  logic [3*POS_W-1:0] pos_old;
  logic [3*CH_W-1:0] col_new;

  logic [LIFE_W-1:0] r_life;
  logic [3*POS_W-1:0] r_pos;
  logic [3*SPEED_W-1:0] r_vel;
  logic [4*CH_W-1:0] r_col;
  logic [SIZE_W-1:0] r_size;
  assign {r_life, r_pos, r_vel, r_col, r_size} = rd;

  logic [IW-1:0] spawn_idx;
  logic [POS_W-1:0] z_ext;
  assign spawn_idx = found ? found_idx : '0;
  assign z_ext = POS_W'($signed(start_z));

  logic [3*POS_W-1:0] pos_new;
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      logic signed [POS_W:0] sum;
      logic signed [SPEED_W+DELTA_W-10:0] step;
      step = prod[a][SPEED_W+DELTA_W:10];
      sum = (POS_W+1)'($signed(pos_old[a*POS_W +: POS_W])) + (POS_W+1)'(step);
      if (sum[POS_W] != sum[POS_W-1])
        pos_new[a*POS_W +: POS_W] = sum[POS_W] ? {1'b1, {(POS_W-1){1'b0}}}
                                               : {1'b0, {(POS_W-1){1'b1}}};
      else pos_new[a*POS_W +: POS_W] = sum[POS_W-1:0];
    end
  end

  logic scan_last;
  assign scan_last = (idx == IW'(POOL_DEPTH-1));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_bits <= '0;
      search_start <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.load_spawn || cmd.load_empty || (cmd.load_out && any_emitted))
        out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.take_item) begin
        action <= in_action;
        delta <= in_delta;
        speed <= in_speed;
        opacity <= in_opacity;
        psize <= in_size;
        idx <= (in_action == ACT_TICK) ? '0 : search_start;
        wrapped <= 1'b0;
        found <= 1'b0;
        found_idx <= '0;
        any_emitted <= 1'b0;
      end
      if (cmd.scan_step) begin
        if (action == ACT_SPAWN && scan_last) begin
          idx <= '0;
          wrapped <= 1'b1;
        end else idx <= idx + 1'b1;
      end
      if (action == ACT_SPAWN && !found && !cmd.take_item && !valid_bits[idx]) begin
        found <= 1'b1;
        found_idx <= idx;
      end
      if (cmd.read_slot) rd <= mem[cmd.scan_step ? idx + 1'b1 : idx];
      if (cmd.calc) begin
        survives <= r_life > LIFE_W'(delta);
        life_new <= r_life - LIFE_W'(delta);
        for (int a = 0; a < 3; a++)
          prod[a] <= $signed(r_vel[a*SPEED_W +: SPEED_W]) * $signed({1'b0, delta});
        pos_old <= r_pos;
        col_new <= {decay(r_col[4*CH_W-1 -: CH_W], targets[3*CH_W-1 -: CH_W]),
                    decay(r_col[3*CH_W-1 -: CH_W], targets[2*CH_W-1 -: CH_W]),
                    decay(r_col[2*CH_W-1 -: CH_W], targets[CH_W-1:0])};
        if (r_life <= LIFE_W'(delta)) valid_bits[idx] <= 1'b0;
      end
      if (cmd.load_out) begin
        any_emitted <= 1'b1;
        pend <= {KIND_LIVE, SLOT_W'(idx), pos_new, r_size, col_new, r_col[CH_W-1:0]};
        if (any_emitted) out_word <= {pend, 1'b0};
      end
      if (cmd.load_empty) begin
        out_word <= any_emitted ? {pend, 1'b1}
                                : {KIND_EMPTY, {(SLOT_W+3*POS_W+SIZE_W+4*CH_W){1'b0}}, 1'b1};
      end
      if (cmd.spawn_write) begin
        valid_bits[spawn_idx] <= 1'b1;
        if (found) search_start <= spawn_idx;
      end
      if (cmd.load_spawn) begin
        out_word <= {KIND_SPAWN, SLOT_W'(spawn_idx), z_ext, {(2*POS_W){1'b0}}, psize,
                     {(3*CH_W){1'b1}}, opacity, 1'b1};
      end
    end
  end

  // slot memory: one write port
  always_ff @(posedge clk) begin
    if (cmd.spawn_write)
      mem[spawn_idx] <= {spawn_life, z_ext, {(2*POS_W){1'b0}}, speed,
                         {(3*CH_W){1'b1}}, opacity, psize};
    else if (cmd.load_out)
      mem[idx] <= {life_new, pos_new, r_vel, col_new, r_col[CH_W-1:0], r_size};
  end

  assign sts.action = action;
  assign sts.cur_valid = valid_bits[idx];
  assign sts.scan_done = (action == ACT_SPAWN) ? (wrapped && idx == search_start - 1'b1)
                                                || (wrapped && search_start == '0)
                                               : scan_last;
  assign sts.found = found || !valid_bits[idx];
  assign sts.survives = survives;
  assign last_busy_last = out_word[0];

endmodule
`default_nettype wire
